// ----- rtl/code128_b_bar_encoder_assert.svh -----
// assertion macros shared by the encoder modules
`ifndef CODE128_B_BAR_ENCODER_ASSERT_SVH
`define CODE128_B_BAR_ENCODER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CBE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CBE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/cbe_pkg.sv -----
// types, constants and the symbol pattern table of the code 128 set b encoder
`timescale 1ns / 1ps

package cbe_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic [6:0] CHAR_FIRST  = 7'd32;
    localparam logic [6:0] CHAR_LAST   = 7'd126;
    localparam logic [6:0] SYM_START_B = 7'd104;
    localparam logic [6:0] SYM_STOP    = 7'd106;
    localparam logic [6:0] MOD_CHECK   = 7'd103;
    localparam logic [3:0] QUIET_WIDTH = 4'd10;
    localparam logic [3:0] STOP_BAR    = 4'd2;
    localparam logic [13:0] POS_MAX    = 14'd16383;

    typedef struct packed {
        logic       open_sym;
        logic       data_sym;
        logic       close_sym;
        logic [6:0] value;
    } cmd_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_QZ_OPEN,
        PH_START,
        PH_DATA,
        PH_CHECK,
        PH_STOP,
        PH_QZ_CLOSE
    } phase_t;

    // six element widths per symbol, one hex digit each, leftmost first
    localparam logic [23:0] SYM_PATTERN [0:106] = '{
        24'h212222, 24'h222122, 24'h222221, 24'h121223, 24'h121322,
        24'h131222, 24'h122213, 24'h122312, 24'h132212, 24'h221213,
        24'h221312, 24'h231212, 24'h112232, 24'h122132, 24'h122231,
        24'h113222, 24'h123122, 24'h123221, 24'h223211, 24'h221132,
        24'h221231, 24'h213212, 24'h223112, 24'h312131, 24'h311222,
        24'h321122, 24'h321221, 24'h312212, 24'h322112, 24'h322211,
        24'h212123, 24'h212321, 24'h232121, 24'h111323, 24'h131123,
        24'h131321, 24'h112313, 24'h132113, 24'h132311, 24'h211313,
        24'h231113, 24'h231311, 24'h112133, 24'h112331, 24'h132131,
        24'h113123, 24'h113321, 24'h133121, 24'h313121, 24'h211331,
        24'h231131, 24'h213113, 24'h213311, 24'h213131, 24'h311123,
        24'h311321, 24'h331121, 24'h312113, 24'h312311, 24'h332111,
        24'h314111, 24'h221411, 24'h431111, 24'h111224, 24'h111422,
        24'h121124, 24'h121421, 24'h141122, 24'h141221, 24'h112214,
        24'h112412, 24'h122114, 24'h122411, 24'h142112, 24'h142211,
        24'h241211, 24'h221114, 24'h413111, 24'h241112, 24'h134111,
        24'h111242, 24'h121142, 24'h121241, 24'h114212, 24'h124112,
        24'h124211, 24'h411212, 24'h421112, 24'h421211, 24'h212141,
        24'h214121, 24'h412121, 24'h111143, 24'h111341, 24'h131141,
        24'h114113, 24'h114311, 24'h411113, 24'h411311, 24'h113141,
        24'h114131, 24'h311141, 24'h411131, 24'h211412, 24'h211214,
        24'h211232, 24'h233111
    };

    // 128 is 25 mod 103, so fold the high bits down twice and finish by subtraction
    function automatic logic [6:0] mod103_fold(input logic [11:0] x);
        logic [9:0] y2;
        logic [7:0] y3;
        logic [7:0] r;
        y2 = 10'({x[11:7], 4'b0} + {x[11:7], 3'b0} + x[11:7]) + 10'(x[6:0]);
        y3 = 8'({y2[9:7], 4'b0} + {y2[9:7], 3'b0} + y2[9:7]) + 8'(y2[6:0]);
        if (y3 >= 8'(2 * MOD_CHECK)) begin
            r = y3 - 8'(2 * MOD_CHECK);
        end else if (y3 >= 8'(MOD_CHECK)) begin
            r = y3 - 8'(MOD_CHECK);
        end else begin
            r = y3;
        end
        return r[6:0];
    endfunction

endpackage

// ----- rtl/code128_b_bar_encoder.sv -----
// top level of the code 128 set b bar encoder
//
//  channel | direction | tdata (low bit up)                        | tlast
//  s_      | in        | char_code[6:0], zero                      | last_char
//  m_      | out       | element_width[3:0], ink_on, start_module  | last_element
//
// one element per cycle leaves the back end while m_tready allows; a data character
// yields six elements, the first of a message seven more, the closing one fourteen more
// the front takes a character per cycle until the four-entry command queue fills
// aresetn is synchronous and clears the open symbol, checksum and module position
// a stalled m_ transfer holds the back end; the front keeps filling the queue
`timescale 1ns / 1ps

module code128_b_bar_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_code[6:0], zero pad
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // element_width[3:0], ink_on, start_module[13:0], zero pad
    output logic        m_tlast
);

    logic          q_full;
    logic          q_push;
    cbe_pkg::cmd_t push_cmd;
    logic          q_pop;
    logic          q_not_empty;
    cbe_pkg::cmd_t head_cmd;
    logic [3:0]    element_width;
    logic          ink_on;
    logic [13:0]   start_module;

    cbe_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .char_code (s_tdata[6:0]),
        .last_char (s_tlast),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    cbe_cmd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    cbe_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_not_empty),
        .q_cmd         (head_cmd),
        .q_pop         (q_pop),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .element_width (element_width),
        .ink_on        (ink_on),
        .start_module  (start_module),
        .last_element  (m_tlast)
    );

    assign m_tdata = {5'b0, start_module, ink_on, element_width};

endmodule

// ----- rtl/cbe_front.sv -----
// front end: takes characters, tracks the open symbol and issues element commands
`timescale 1ns / 1ps

module cbe_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [6:0]    char_code,
    input  logic          last_char,
    input  logic          q_full,
    output logic          q_push,
    output cbe_pkg::cmd_t q_cmd
);

    logic in_symbol_reg;
    logic in_symbol_next;
    logic printable;
    logic accept;

    assign printable = (char_code >= cbe_pkg::CHAR_FIRST) && (char_code <= cbe_pkg::CHAR_LAST);
    assign s_tready  = !q_full;
    assign accept    = s_tvalid && !q_full;

    always_comb begin
        q_cmd.open_sym  = printable && !in_symbol_reg;
        q_cmd.data_sym  = printable;
        q_cmd.close_sym = last_char && (printable || in_symbol_reg);
        q_cmd.value     = char_code - cbe_pkg::CHAR_FIRST;
        q_push          = accept && (printable || q_cmd.close_sym);
        in_symbol_next  = in_symbol_reg;
        if (accept) begin
            if (q_cmd.close_sym) begin
                in_symbol_next = 1'b0;
            end else if (printable) begin
                in_symbol_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_symbol_reg <= 1'b0;
        end else begin
            in_symbol_reg <= in_symbol_next;
        end
    end

endmodule

// ----- rtl/cbe_cmd_queue.sv -----
// short command queue between front and back
`timescale 1ns / 1ps

module cbe_cmd_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  cbe_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output cbe_pkg::cmd_t head_cmd
);

    `include "code128_b_bar_encoder_assert.svh"

    cbe_pkg::cmd_t                mem_reg [cbe_pkg::QDEPTH];
    logic [cbe_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [cbe_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [cbe_pkg::QPTR_W:0]     count_reg;
    logic                         do_push;
    logic                         do_pop;

    assign full      = (count_reg == (cbe_pkg::QPTR_W + 1)'(cbe_pkg::QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    `CBE_ASSERT_NOW(a_count_bound, 1'b1,
        count_reg <= (cbe_pkg::QPTR_W + 1)'(cbe_pkg::QDEPTH), "queue count above depth")
    `CBE_ASSERT_NEXT(a_empty_stays, !not_empty && !push, !not_empty, "queue filled without push")
    `CBE_ASSERT_NEXT(a_full_stays, full && !pop, full, "queue drained without pop")

endmodule

// ----- rtl/cbe_back.sv -----
// back end: steps through the element sequence of each command and keeps the checksum
`timescale 1ns / 1ps

module cbe_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    input  cbe_pkg::cmd_t q_cmd,
    output logic          q_pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [3:0]    element_width,
    output logic          ink_on,
    output logic [13:0]   start_module,
    output logic          last_element
);

    `include "code128_b_bar_encoder_assert.svh"

    cbe_pkg::phase_t phase_reg, phase_next;
    logic [2:0]      k_reg, k_next;
    cbe_pkg::cmd_t   cmd_reg, cmd_next;
    logic [13:0]     pos_reg, pos_next;
    logic [6:0]      cs_reg, cs_next;
    logic [6:0]      wt_reg, wt_next;
    logic [13:0]     prod_reg, prod_next;
    logic [11:0]     fold_reg, fold_next;

    logic            m_valid_reg;
    logic [3:0]      m_width_reg;
    logic            m_ink_reg;
    logic [13:0]     m_start_reg;
    logic            m_last_reg;

    logic [6:0]      sym_val;
    logic [23:0]     pat;
    logic [3:0]      digit;
    logic [3:0]      el_width;
    logic            is_qz;
    logic [2:0]      last_idx;
    logic            phase_end;
    logic            cmd_end;
    logic            can_emit;
    logic [14:0]     pos_sum;
    cbe_pkg::phase_t first_phase;
    cbe_pkg::phase_t after_phase;

    assign m_tvalid      = m_valid_reg;
    assign element_width = m_width_reg;
    assign ink_on        = m_ink_reg;
    assign start_module  = m_start_reg;
    assign last_element  = m_last_reg;

    always_comb begin
        case (phase_reg)
            cbe_pkg::PH_START: sym_val = cbe_pkg::SYM_START_B;
            cbe_pkg::PH_DATA:  sym_val = cmd_reg.value;
            cbe_pkg::PH_CHECK: sym_val = cs_reg;
            default:           sym_val = cbe_pkg::SYM_STOP;
        endcase
        pat = cbe_pkg::SYM_PATTERN[sym_val];
        case (k_reg)
            3'd0:    digit = pat[23:20];
            3'd1:    digit = pat[19:16];
            3'd2:    digit = pat[15:12];
            3'd3:    digit = pat[11:8];
            3'd4:    digit = pat[7:4];
            3'd5:    digit = pat[3:0];
            default: digit = cbe_pkg::STOP_BAR;
        endcase
        is_qz    = (phase_reg == cbe_pkg::PH_QZ_OPEN) || (phase_reg == cbe_pkg::PH_QZ_CLOSE);
        el_width = is_qz ? cbe_pkg::QUIET_WIDTH : digit;
        case (phase_reg)
            cbe_pkg::PH_QZ_OPEN:  last_idx = 3'd0;
            cbe_pkg::PH_QZ_CLOSE: last_idx = 3'd0;
            cbe_pkg::PH_STOP:     last_idx = 3'd6;
            default:              last_idx = 3'd5;
        endcase
        phase_end = (k_reg == last_idx);
        cmd_end   = phase_end && ((phase_reg == cbe_pkg::PH_QZ_CLOSE) ||
                    ((phase_reg == cbe_pkg::PH_DATA) && !cmd_reg.close_sym));
        can_emit  = (phase_reg != cbe_pkg::PH_IDLE) && (!m_valid_reg || m_tready);
        q_pop     = q_valid && ((phase_reg == cbe_pkg::PH_IDLE) || (can_emit && cmd_end));

        if (q_cmd.open_sym) begin
            first_phase = cbe_pkg::PH_QZ_OPEN;
        end else if (q_cmd.data_sym) begin
            first_phase = cbe_pkg::PH_DATA;
        end else begin
            first_phase = cbe_pkg::PH_CHECK;
        end
        case (phase_reg)
            cbe_pkg::PH_QZ_OPEN: after_phase = cbe_pkg::PH_START;
            cbe_pkg::PH_START:   after_phase = cbe_pkg::PH_DATA;
            cbe_pkg::PH_DATA:    after_phase = cbe_pkg::PH_CHECK;
            cbe_pkg::PH_CHECK:   after_phase = cbe_pkg::PH_STOP;
            cbe_pkg::PH_STOP:    after_phase = cbe_pkg::PH_QZ_CLOSE;
            default:             after_phase = cbe_pkg::PH_IDLE;
        endcase

        pos_sum = {1'b0, pos_reg} + 15'(el_width);

        phase_next = phase_reg;
        k_next     = k_reg;
        cmd_next   = cmd_reg;
        pos_next   = pos_reg;
        cs_next    = cs_reg;
        wt_next    = wt_reg;
        prod_next  = prod_reg;
        fold_next  = fold_reg;

        if (phase_reg == cbe_pkg::PH_IDLE) begin
            if (q_valid) begin
                phase_next = first_phase;
                cmd_next   = q_cmd;
                k_next     = 3'd0;
            end
        end else if (can_emit) begin
            k_next = phase_end ? 3'd0 : k_reg + 3'd1;
            if (phase_end) begin
                if (cmd_end) begin
                    phase_next = q_valid ? first_phase : cbe_pkg::PH_IDLE;
                    cmd_next   = q_valid ? q_cmd : cmd_reg;
                end else begin
                    phase_next = after_phase;
                end
            end
            pos_next = (pos_sum > 15'(cbe_pkg::POS_MAX)) ? cbe_pkg::POS_MAX : pos_sum[13:0];
            case (phase_reg)
                cbe_pkg::PH_QZ_OPEN: begin
                    cs_next = 7'(cbe_pkg::SYM_START_B - cbe_pkg::MOD_CHECK);
                    wt_next = 7'd1;
                end
                cbe_pkg::PH_DATA: begin
                    if (k_reg == 3'd0) begin
                        prod_next = 14'(wt_reg * cmd_reg.value);
                    end else if (k_reg == 3'd1) begin
                        fold_next = 12'({prod_reg[13:7], 4'b0} + {prod_reg[13:7], 3'b0}
                                    + prod_reg[13:7]) + 12'(prod_reg[6:0]) + 12'(cs_reg);
                    end else if (k_reg == 3'd2) begin
                        cs_next = cbe_pkg::mod103_fold(fold_reg);
                        wt_next = (wt_reg == cbe_pkg::MOD_CHECK - 7'd1) ? 7'd0 : wt_reg + 7'd1;
                    end
                end
                cbe_pkg::PH_QZ_CLOSE: begin
                    pos_next = '0;
                    cs_next  = '0;
                    wt_next  = '0;
                end
                default: begin
                    cs_next = cs_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= cbe_pkg::PH_IDLE;
            k_reg       <= '0;
            pos_reg     <= '0;
            cs_reg      <= '0;
            wt_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            k_reg     <= k_next;
            pos_reg   <= pos_next;
            cs_reg    <= cs_next;
            wt_reg    <= wt_next;
            if (can_emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        prod_reg <= prod_next;
        fold_reg <= fold_next;
        if (can_emit) begin
            m_width_reg <= el_width;
            m_ink_reg   <= !is_qz && !k_reg[0];
            m_start_reg <= pos_reg;
            m_last_reg  <= cmd_end;
        end
    end

    `CBE_ASSERT_NOW(a_cs_range, 1'b1, cs_reg < cbe_pkg::MOD_CHECK, "checksum out of range")
    `CBE_ASSERT_NOW(a_quiet_white, m_valid_reg && (m_width_reg == cbe_pkg::QUIET_WIDTH),
        !m_ink_reg, "quiet zone drawn in ink")
    `CBE_ASSERT_NEXT(a_hold_stalled, m_valid_reg && !m_tready,
        m_valid_reg && $stable(m_start_reg), "stalled element changed")

endmodule

// ----- tb/code128_b_bar_encoder_checker.sv -----
// checker for the code 128 set b bar encoder: predicts every bar and space and compares transfers
`timescale 1ns / 1ps

module code128_b_bar_encoder_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_code[6:0], zero pad
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // element_width[3:0], ink_on, start_module[13:0], zero pad
    input  logic        m_tlast,
    output int          errors,
    output int          outstanding,
    output int          elements_checked,
    output int          symbols_closed
);

    localparam int unsigned FIRST_PRINTABLE = 32;
    localparam int unsigned LAST_PRINTABLE  = 126;
    localparam int unsigned CHECK_MODULUS   = 103;
    localparam int unsigned START_B_VALUE   = 104;
    localparam int unsigned STOP_VALUE      = 106;
    localparam int unsigned QUIET_MODULES   = 10;
    localparam int unsigned STOP_TAIL_BAR   = 2;
    localparam int unsigned MODULE_CEILING  = 16383;
    localparam int unsigned MAX_REPORTS     = 200;
    localparam int unsigned PATTERN_CHARS   = 107 * 6;

    // six widths per symbol value, bar first
    localparam bit [107*48-1:0] BAR_PATTERNS = {
        "212222", "222122", "222221", "121223", "121322",
        "131222", "122213", "122312", "132212", "221213",
        "221312", "231212", "112232", "122132", "122231",
        "113222", "123122", "123221", "223211", "221132",
        "221231", "213212", "223112", "312131", "311222",
        "321122", "321221", "312212", "322112", "322211",
        "212123", "212321", "232121", "111323", "131123",
        "131321", "112313", "132113", "132311", "211313",
        "231113", "231311", "112133", "112331", "132131",
        "113123", "113321", "133121", "313121", "211331",
        "231131", "213113", "213311", "213131", "311123",
        "311321", "331121", "312113", "312311", "332111",
        "314111", "221411", "431111", "111224", "111422",
        "121124", "121421", "141122", "141221", "112214",
        "112412", "122114", "122411", "142112", "142211",
        "241211", "221114", "413111", "241112", "134111",
        "111242", "121142", "121241", "114212", "124112",
        "124211", "411212", "421112", "421211", "212141",
        "214121", "412121", "111143", "111341", "131141",
        "114113", "114311", "411113", "411311", "113141",
        "114131", "311141", "411131", "211412", "211214",
        "211232", "233111"
    };

    typedef struct packed {
        logic [3:0]  width;
        logic        ink;
        logic [13:0] start;
        logic        last;
    } bar_elem_t;

    bar_elem_t   expected_elements [$];
    logic        sym_open;
    logic [6:0]  check_acc;
    logic [6:0]  char_pos;
    logic [13:0] next_module;

    initial begin
        errors = 0;
        outstanding = 0;
        elements_checked = 0;
        symbols_closed = 0;
    end

    function automatic int unsigned pattern_width(input int unsigned value, input int unsigned k);
        int unsigned idx;
        bit [7:0]    digit;
        idx = PATTERN_CHARS - 1 - (value * 6 + k);
        digit = BAR_PATTERNS[idx*8 +: 8];
        return digit - 8'd48;
    endfunction

    task automatic clear_symbol();
        sym_open = 1'b0;
        check_acc = '0;
        char_pos = '0;
        next_module = '0;
    endtask

    task automatic push_element(input int unsigned width, input logic ink);
        bar_elem_t   e;
        int unsigned reach;
        e.width = 4'(width);
        e.ink = ink;
        e.start = next_module;
        e.last = 1'b0;
        expected_elements.insert(expected_elements.size(), e);
        reach = next_module + width;
        next_module = (reach > MODULE_CEILING) ? 14'(MODULE_CEILING) : 14'(reach);
    endtask

    task automatic push_symbol(input int unsigned value);
        for (int unsigned k = 0; k < 6; k++)
            push_element(pattern_width(value, k), (k % 2) == 0);
        if (value == STOP_VALUE)
            push_element(STOP_TAIL_BAR, 1'b1);
    endtask

    task automatic encode_char(input logic [6:0] c, input logic last);
        int unsigned n_start;
        int unsigned value;
        int unsigned tail_idx;
        bar_elem_t   tail;
        n_start = expected_elements.size();
        if (c >= FIRST_PRINTABLE && c <= LAST_PRINTABLE) begin
            value = c - FIRST_PRINTABLE;
            if (!sym_open) begin
                next_module = '0;
                push_element(QUIET_MODULES, 1'b0);
                push_symbol(START_B_VALUE);
                check_acc = 7'(START_B_VALUE % CHECK_MODULUS);
                char_pos = 7'd1;
                sym_open = 1'b1;
            end
            push_symbol(value);
            check_acc = 7'((check_acc + char_pos * value) % CHECK_MODULUS);
            char_pos = 7'((char_pos + 1) % CHECK_MODULUS);
        end
        // closing still happens when the final character itself is dropped
        if (last && sym_open) begin
            push_symbol(check_acc);
            push_symbol(STOP_VALUE);
            push_element(QUIET_MODULES, 1'b0);
            clear_symbol();
            symbols_closed++;
        end
        if (expected_elements.size() > n_start) begin
            tail_idx = expected_elements.size() - 1;
            tail = expected_elements[tail_idx];
            tail.last = 1'b1;
            expected_elements[tail_idx] = tail;
        end
    endtask

    task automatic report_mismatch(input string what);
        if (errors < MAX_REPORTS)
            $display("%0t element %0d: %s", $time, elements_checked, what);
        errors++;
    endtask

    task automatic check_element();
        bar_elem_t want;
        if (expected_elements.size() == 0) begin
            report_mismatch($sformatf("transfer with nothing expected, tdata %h", m_tdata));
        end else begin
            want = expected_elements.pop_front();
            if (m_tdata[3:0] !== want.width)
                report_mismatch($sformatf("element_width %0d, wanted %0d",
                                          m_tdata[3:0], want.width));
            if (m_tdata[4] !== want.ink)
                report_mismatch($sformatf("ink_on %0b, wanted %0b", m_tdata[4], want.ink));
            if (m_tdata[18:5] !== want.start)
                report_mismatch($sformatf("start_module %0d, wanted %0d",
                                          m_tdata[18:5], want.start));
            if (m_tlast !== want.last)
                report_mismatch($sformatf("last_element %0b, wanted %0b", m_tlast, want.last));
        end
        elements_checked++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_symbol();
            expected_elements.delete();
        end else begin
            if (s_tvalid && s_tready)
                encode_char(s_tdata[6:0], s_tlast);
            if (m_tvalid && m_tready)
                check_element();
        end
        outstanding <= expected_elements.size();
    end

endmodule

// ----- tb/code128_b_bar_encoder_tb.sv -----
// testbench top for the code 128 set b bar encoder: stimulus, pacing, watchdog and verdict
`timescale 1ns / 1ps

module code128_b_bar_encoder_tb;

    localparam int ITEM_TARGET  = 150;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 40;

    localparam logic [6:0] CHAR_NUL     = 7'h00;
    localparam logic [6:0] CHAR_US      = 7'h1f;
    localparam logic [6:0] CHAR_SPACE   = 7'h20;
    localparam logic [6:0] CHAR_UPPER_A = 7'h41;
    localparam logic [6:0] CHAR_LOWER_L = 7'h6c;
    localparam logic [6:0] CHAR_TILDE   = 7'h7e;
    localparam logic [6:0] CHAR_DEL     = 7'h7f;

    typedef enum int {
        PACE_FULL,
        PACE_RANDOM,
        PACE_BURSTY
    } pace_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    int    errors;
    int    outstanding;
    int    elements_checked;
    int    symbols_closed;
    pace_t s_pace = PACE_FULL;
    pace_t m_pace = PACE_FULL;
    int    chars_sent = 0;
    int    chars_ignored = 0;
    int    idle_cycles = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    code128_b_bar_encoder u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    code128_b_bar_encoder_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tlast          (s_tlast),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tlast          (m_tlast),
        .errors           (errors),
        .outstanding      (outstanding),
        .elements_checked (elements_checked),
        .symbols_closed   (symbols_closed)
    );

    function automatic int unsigned draw_wait(input pace_t pace);
        int unsigned n;
        case (pace)
            PACE_FULL: begin
                n = 0;
            end
            PACE_RANDOM: begin
                n = $urandom_range(0, 17);
            end
            default: begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
            end
        endcase
        return n;
    endfunction

    function automatic logic [6:0] random_unprintable();
        int unsigned u;
        u = $urandom_range(0, 32);
        return (u == 32) ? CHAR_DEL : 7'(u);
    endfunction

    function automatic logic [6:0] random_char();
        logic [6:0] c;
        if ($urandom_range(0, 9) == 0)
            c = 7'($urandom_range(0, 127));
        else
            c = 7'($urandom_range(CHAR_SPACE, CHAR_TILDE));
        return c;
    endfunction

    task automatic send_char(input logic [6:0] c, input logic last);
        int unsigned gap;
        gap = draw_wait(s_pace);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, c};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        chars_sent++;
        if ((c < CHAR_SPACE) || (c > CHAR_TILDE))
            chars_ignored++;
    endtask

    // hold the sender off until every predicted element has arrived
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    initial begin
        int unsigned stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = draw_wait(m_pace);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("no transfer on either channel for %0d cycles", IDLE_LIMIT);
                $display("code128_b_bar_encoder: mismatch");
                $finish;
            end
        end
    end

    initial begin
        int unsigned len;
        logic [6:0]  c;
        logic        drained_midway;
        string       word;
        drained_midway = 1'b0;
        word = "Code 128";
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // range ends as one-character symbols, dropped codes in and out of a symbol
        send_char(CHAR_SPACE, 1'b1);
        send_char(CHAR_TILDE, 1'b1);
        send_char(CHAR_NUL, 1'b1);
        send_char(CHAR_DEL, 1'b0);
        send_char(CHAR_LOWER_L, 1'b0);
        send_char(CHAR_US, 1'b0);
        send_char(CHAR_UPPER_A, 1'b0);
        send_char(CHAR_DEL, 1'b1);
        s_pace = PACE_RANDOM;
        m_pace = PACE_RANDOM;
        for (int i = 0; i < word.len(); i++)
            send_char(7'(word[i]), i == word.len() - 1);
        drain_results();

        while (chars_sent < ITEM_TARGET) begin
            if (chars_sent > ITEM_TARGET / 2 && !drained_midway) begin
                drain_results();
                drained_midway = 1'b1;
            end
            if ($urandom_range(0, 15) == 0) begin
                s_pace = pace_t'($urandom_range(0, 2));
                m_pace = pace_t'($urandom_range(0, 2));
            end
            if ($urandom_range(0, 9) == 0) begin
                send_char(random_unprintable(), 1'($urandom_range(0, 1)));
            end else begin
                len = $urandom_range(1, 8);
                for (int unsigned i = 0; i < len; i++) begin
                    c = random_char();
                    if (i == len - 1 && $urandom_range(0, 7) == 0)
                        c = random_unprintable();
                    send_char(c, i == len - 1);
                end
            end
        end

        s_pace = PACE_RANDOM;
        m_pace = PACE_RANDOM;
        send_char(random_char(), 1'b0);
        send_char(CHAR_TILDE, 1'b1);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("%0d characters sent (%0d dropped), %0d symbols closed, %0d elements compared",
                 chars_sent, chars_ignored, symbols_closed, elements_checked);
        $display("short random messages under mixed pacing, dropped codes inside and outside");
        if (errors == 0 && outstanding == 0)
            $display("code128_b_bar_encoder: match");
        else
            $display("code128_b_bar_encoder: mismatch");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/cbe_pkg.sv
rtl/cbe_front.sv
rtl/cbe_cmd_queue.sv
rtl/cbe_back.sv
rtl/code128_b_bar_encoder.sv
tb/code128_b_bar_encoder_checker.sv
tb/code128_b_bar_encoder_tb.sv
